FILE: rtl/lpfc_pkg.sv
package lpfc_pkg;

    // Table geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // APB register map
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ENTRIES_IN_USE = 3'd0;
    localparam logic [CAP_W-1:0]   ENTRIES_IN_USE_RST  = 5'd16;

    // Command codes
    localparam logic [1:0] CMD_LOOKUP   = 2'd0;
    localparam logic [1:0] CMD_COMPLETE = 2'd1;
    localparam logic [1:0] CMD_EVICT    = 2'd2;

    typedef enum logic [1:0] {
        ST_LOADING = 2'd0,
        ST_READY   = 2'd1,
        ST_FAILED  = 2'd2
    } status_t;

    // One word of the entry memory
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        status_t             status;
        logic [31:0]         handle;
        logic [31:0]         stamp;
    } entry_t;

    // What a full pass over the table found
    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        entry_t           match_entry;
        logic             victim_found;
        logic [IDX_W-1:0] victim_idx;
        logic [KEY_BITS-1:0] victim_key;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count;
    } scan_res_t;

endpackage

FILE: rtl/lpfc_mem.sv
module lpfc_mem
    import lpfc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lpfc_scan.sv
module lpfc_scan
    import lpfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                step,
    input  logic [IDX_W-1:0]    idx,
    input  logic                vbit,
    input  entry_t              rdata,
    input  logic [KEY_BITS-1:0] key,
    input  logic [31:0]         now,
    output scan_res_t           res
);

    scan_res_t   res_reg;
    scan_res_t   res_next;
    logic [31:0] best_reg;
    logic [31:0] best_next;
    logic [31:0] age;

    assign age = now - rdata.stamp;

    // Fold one entry into the running match, victim, free slot and count
    always_comb
    begin
        res_next  = res_reg;
        best_next = best_reg;
        if (clear)
        begin
            res_next  = '0;
            best_next = '0;
        end
        else if (step)
        begin
            if (vbit)
            begin
                res_next.count = res_reg.count + CNT_W'(1);
            end
            if (vbit && !res_reg.match_found && (rdata.key == key))
            begin
                res_next.match_found = 1'b1;
                res_next.match_idx   = idx;
                res_next.match_entry = rdata;
            end
            if (vbit && (rdata.status != ST_LOADING) &&
                (!res_reg.victim_found || (age > best_reg)))
            begin
                res_next.victim_found = 1'b1;
                res_next.victim_idx   = idx;
                res_next.victim_key   = rdata.key;
                best_next             = age;
            end
            if (!vbit && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            best_reg <= best_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/lru_pending_fetch_cache.sv
// A start transfer leads through S_SCAN and S_FIN; done is registered from S_FIN.
// No new command is taken while busy; the table is walked one entry
// per cycle through the single read port of the entry memory.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset clears the valid bits, the access counter and sets entries_in_use to 16;
// no clearing pass is needed, so commands are taken right after reset.
module lru_pending_fetch_cache
    import lpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [31:0]        key,
    input  logic               fetch_ok,
    input  logic [31:0]        loaded_handle,
    // result channel
    output logic               done,
    output logic               hit,
    output logic               ready_res,
    output logic [31:0]        texture_handle,
    output logic               start_fetch,
    output logic               evicted,
    output logic [31:0]        evicted_key,
    output logic               refused,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [31:0]         clock_reg;
    logic [31:0]         clock_next;
    logic [CAP_W-1:0]    eiu_reg;

    logic [1:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                ok_reg;
    logic [31:0]         lh_reg;

    logic                done_reg;
    logic                hit_reg;
    logic                rdy_reg;
    logic [31:0]         th_reg;
    logic                sf_reg;
    logic                ev_reg;
    logic [31:0]         evk_reg;
    logic                ref_reg;

    logic                accept;
    logic                last;
    logic                cfg_wr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    entry_t              mem_rdata;
    scan_res_t           res;

    logic [CMP_W-1:0]    cap;
    logic                full;
    logic [IDX_W-1:0]    slot;
    logic                f_hit;
    logic                f_rdy;
    logic [31:0]         f_th;
    logic                f_sf;
    logic                f_ev;
    logic [31:0]         f_evk;
    logic                f_ref;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign last   = (idx_reg == IDX_W'(ENTRIES - 1));

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ENTRIES_IN_USE);
    assign prdata = (paddr == ADDR_ENTRIES_IN_USE) ? {27'd0, eiu_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= ENTRIES_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            eiu_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Saturate the capacity limit to 1..ENTRIES
    always_comb
    begin
        cap = CMP_W'(eiu_reg);
        if (eiu_reg == '0)
        begin
            cap = CMP_W'(1);
        end
        else if (CMP_W'(eiu_reg) > CMP_W'(ENTRIES))
        begin
            cap = CMP_W'(ENTRIES);
        end
    end

    assign full = (CMP_W'(res.count) >= cap);

    // Walk the table: read entry idx+1 while entry idx is folded in
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (accept)
        begin
            mem_re = 1'b1;
        end
        else if ((state_reg == S_SCAN) && !last)
        begin
            mem_re    = 1'b1;
            mem_raddr = idx_reg + IDX_W'(1);
        end
    end

    lpfc_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lpfc_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .step  (state_reg == S_SCAN),
        .idx   (idx_reg),
        .vbit  (valid_reg[idx_reg]),
        .rdata (mem_rdata),
        .key   (key_reg),
        .now   (clock_reg),
        .res   (res)
    );

    // Apply the command once the pass is complete
    always_comb
    begin
        valid_next = valid_reg;
        clock_next = clock_reg;
        mem_we     = 1'b0;
        mem_waddr  = res.match_idx;
        mem_wdata  = res.match_entry;
        slot       = res.free_idx;
        f_hit      = 1'b0;
        f_rdy      = 1'b0;
        f_th       = '0;
        f_sf       = 1'b0;
        f_ev       = 1'b0;
        f_evk      = '0;
        f_ref      = 1'b0;
        if (state_reg == S_FIN)
        begin
            case (cmd_reg)
                CMD_LOOKUP:
                begin
                    clock_next = clock_reg + 32'd1;
                    if (res.match_found)
                    begin
                        f_hit           = 1'b1;
                        mem_we          = 1'b1;
                        mem_wdata.stamp = clock_reg;
                        if (res.match_entry.status == ST_READY)
                        begin
                            f_rdy = 1'b1;
                            f_th  = res.match_entry.handle;
                        end
                    end
                    else if (full && !res.victim_found)
                    begin
                        f_ref = 1'b1;
                    end
                    else
                    begin
                        if (full)
                        begin
                            f_ev  = 1'b1;
                            f_evk = 32'(res.victim_key);
                            valid_next[res.victim_idx] = 1'b0;
                            if (!res.free_found || (res.victim_idx < res.free_idx))
                            begin
                                slot = res.victim_idx;
                            end
                        end
                        f_sf             = 1'b1;
                        valid_next[slot] = 1'b1;
                        mem_we           = 1'b1;
                        mem_waddr        = slot;
                        mem_wdata.key    = key_reg;
                        mem_wdata.status = ST_LOADING;
                        mem_wdata.handle = '0;
                        mem_wdata.stamp  = clock_reg;
                    end
                end
                CMD_COMPLETE:
                begin
                    if (res.match_found)
                    begin
                        f_hit  = 1'b1;
                        mem_we = 1'b1;
                        if (ok_reg)
                        begin
                            mem_wdata.status = ST_READY;
                            mem_wdata.handle = lh_reg;
                        end
                        else
                        begin
                            mem_wdata.status = ST_FAILED;
                        end
                    end
                end
                CMD_EVICT:
                begin
                    if (res.match_found)
                    begin
                        f_hit = 1'b1;
                        f_ev  = 1'b1;
                        f_evk = 32'(res.match_entry.key);
                        valid_next[res.match_idx] = 1'b0;
                    end
                end
                default:
                begin
                    f_hit = 1'b0;
                end
            endcase
        end
    end

    // Sequence one command through scan and finish
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            clock_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            clock_reg <= clock_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    // Hold the command fields for the whole pass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key[KEY_BITS-1:0];
            ok_reg  <= fetch_ok;
            lh_reg  <= loaded_handle;
        end
    end

    // Register the result for its one-cycle transfer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            hit_reg <= f_hit;
            rdy_reg <= f_rdy;
            th_reg  <= f_th;
            sf_reg  <= f_sf;
            ev_reg  <= f_ev;
            evk_reg <= f_evk;
            ref_reg <= f_ref;
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign ready_res      = rdy_reg;
    assign texture_handle = th_reg;
    assign start_fetch    = sf_reg;
    assign evicted        = ev_reg;
    assign evicted_key    = evk_reg;
    assign refused        = ref_reg;

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("done strobe without a finish cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a start transfer");

    a_refused_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && refused) |-> (!hit && !start_fetch && !evicted))
        else $error("refused result carries other flags");

    a_fetch_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && start_fetch) |-> !hit)
        else $error("fetch requested on a hit");
`endif

endmodule
